### design/bstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_pkg - shared types and constants for the bounded stack
// Storage sizes, operation and status codes, controller states, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bstk_pkg;

	localparam int DEPTH      = 64;
	localparam int WORD_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 7;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 2;
	localparam int FOUND_W    = 6;
	localparam int OCC_W      = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_MISS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SEARCH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    push_wr;    // write word at top, count up
		logic    pop_dec;    // count down
		logic    clear;      // count to zero
		logic    load_key;   // capture search key, index = top - 1
		logic    rd_top;     // read entry top - 1
		logic    rd_next;    // read entry index - 1, step index down
		logic    res_load;   // load result register
		status_t res_status;
		logic    res_data_en;
		logic    res_found_en;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic top_zero;
		logic push_full;
		logic hit;
		logic idx_zero;
	} stat_t;

endpackage

### design/bstk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_ctrl - request sequencer for the bounded stack
// Decodes requests, steps pop/peek reads and the top-down search, and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module bstk_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bstk_pkg::OP_W-1:0]     operation,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  bstk_pkg::stat_t               stat,
	output bstk_pkg::cmd_t                cmd
);
	import bstk_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	op_t    op;

	assign op        = op_t'(operation);
	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = (state_q == S_IDLE) && in_valid && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		in_stall = 1'b1;
		if (state_q == S_IDLE) begin
			in_stall = !out_free;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_POP, OP_PEEK: begin
							if (!stat.top_zero) state_d = S_READ;
						end
						OP_SEARCH: begin
							if (!stat.top_zero) state_d = S_SEARCH;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: begin
				if (out_free) state_d = S_IDLE;
			end
			S_SEARCH: begin
				if ((stat.hit || stat.idx_zero) && out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd            = '0;
		cmd.res_status = STS_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUSH: begin
							cmd.res_load = 1'b1;
							if (stat.push_full) begin
								cmd.res_status = STS_FULL;
							end else begin
								cmd.push_wr = 1'b1;
							end
						end
						OP_POP, OP_PEEK: begin
							if (stat.top_zero) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = STS_EMPTY;
							end else begin
								cmd.rd_top  = 1'b1;
								cmd.pop_dec = (op == OP_POP);
							end
						end
						OP_CLEAR: begin
							cmd.clear    = 1'b1;
							cmd.res_load = 1'b1;
						end
						OP_SEARCH: begin
							if (stat.top_zero) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = STS_MISS;
							end else begin
								cmd.rd_top   = 1'b1;
								cmd.load_key = 1'b1;
							end
						end
						default: cmd.res_load = 1'b1;
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					cmd.res_load    = 1'b1;
					cmd.res_data_en = 1'b1;
				end
			end
			S_SEARCH: begin
				if (stat.hit) begin
					if (out_free) begin
						cmd.res_load     = 1'b1;
						cmd.res_found_en = 1'b1;
					end
				end else if (stat.idx_zero) begin
					if (out_free) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = STS_MISS;
					end
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("input taken while a request is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(out_valid_q && out_stall))
		else $error("pending result overwritten");

endmodule

### design/bstk_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_dpath - storage, counters and result register of the bounded stack
// Holds the entry memory, the entry count, the capacity register, the
// search key and index, and the registered result fields.
// ----------------------------------------------------------------------------
module bstk_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [bstk_pkg::CAP_W-1:0]             cfg_wr_data,
	input  logic signed [bstk_pkg::WORD_WIDTH-1:0] value,
	input  bstk_pkg::cmd_t                         cmd,
	output bstk_pkg::stat_t                        stat,
	output logic [bstk_pkg::STATUS_W-1:0]          status,
	output logic signed [bstk_pkg::WORD_WIDTH-1:0] data,
	output logic [bstk_pkg::FOUND_W-1:0]           found_index,
	output logic [bstk_pkg::OCC_W-1:0]             occupancy,
	output logic                                   is_empty,
	output logic                                   is_full
);
	import bstk_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [WORD_WIDTH-1:0] mem [DEPTH];
	logic [WORD_WIDTH-1:0] rdata_q;
	logic [WORD_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CAP_W-1:0]      cap_q;
	logic [CNT_W-1:0]      cap_eff;
	logic [ADDR_W-1:0]     idx_q;
	logic [CNT_W-1:0]      top_m1;
	logic [ADDR_W-1:0]     raddr;
	logic                  rd_en;

	// clamp in full integer width so any capacity above DEPTH acts as DEPTH
	assign cap_eff = (int'(cap_q) > DEPTH) ? DEPTH_CNT : CNT_W'(cap_q);
	assign top_m1  = count_q - CNT_W'(1);
	assign raddr   = cmd.rd_top ? top_m1[ADDR_W-1:0] : (idx_q - ADDR_W'(1));
	assign rd_en   = cmd.rd_top || cmd.rd_next;

	always_comb begin
		count_d = count_q;
		if (cmd.clear) begin
			count_d = '0;
		end else if (cmd.push_wr) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.pop_dec) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign stat.top_zero  = (count_q == '0);
	assign stat.push_full = (count_q >= cap_eff) || (count_q >= DEPTH_CNT);
	assign stat.hit       = (rdata_q == key_q);
	assign stat.idx_zero  = (idx_q == '0);

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[count_q[ADDR_W-1:0]] <= value;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			count_q <= count_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= value;
			idx_q <= top_m1[ADDR_W-1:0];
		end else if (cmd.rd_next) begin
			idx_q <= idx_q - ADDR_W'(1);
		end
		if (cmd.res_load) begin
			status      <= cmd.res_status;
			data        <= cmd.res_data_en ? rdata_q : '0;
			found_index <= cmd.res_found_en ? FOUND_W'(idx_q) : '0;
			occupancy   <= OCC_W'(count_d);
			is_empty    <= (count_d == '0);
			is_full     <= (count_d >= cap_eff);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count beyond storage depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> (count_q < cap_eff) && !cmd.pop_dec && !cmd.clear)
		else $error("push written without room");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_dec |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop count step wrong");

endmodule

### design/bounded_int_stack_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_int_stack_with_search - bounded LIFO of signed words with search
// Push, pop, peek, clear and a top-down search for a word. Each request
// word returns one result word with status, data, match index, occupancy
// and the empty/full flags. Capacity is a register limited to DEPTH.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------
//  request   in         in_valid / in_stall    operation, value
//  result    out        out_valid / out_stall  status, data, found_index,
//                                              occupancy, is_empty, is_full
//  config    in         cfg_wr_en              cfg_wr_data (capacity)
//
//  Push, clear, unused codes and requests that are refused load the result when taken.
//  Pop and peek first do the registered read of the entry memory.
//  Search on an empty stack returns a miss directly; else it compares the
//  entries top down, one per cycle through the single read port of the
//  entry memory, until a match or the bottom entry.
//  Reset clears the entry count and sets capacity to 64; the entry memory is
//  not cleared, since only pushed entries are ever read.
//  A held result stalls new requests only when out_stall is high; otherwise a
//  new request is taken in the cycle its result register drains.
// ----------------------------------------------------------------------------
module bounded_int_stack_with_search (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [bstk_pkg::CAP_W-1:0]             cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [bstk_pkg::OP_W-1:0]              operation,
	input  logic signed [bstk_pkg::WORD_WIDTH-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [bstk_pkg::STATUS_W-1:0]          status,
	output logic signed [bstk_pkg::WORD_WIDTH-1:0] data,
	output logic [bstk_pkg::FOUND_W-1:0]           found_index,
	output logic [bstk_pkg::OCC_W-1:0]             occupancy,
	output logic                                   is_empty,
	output logic                                   is_full
);
	import bstk_pkg::*;

	// command bundle from the sequencer, status bundle back from storage
	cmd_t  cmd;
	stat_t stat;

	// sequencer: decode requests, step reads and the search walk,
	// and hold the result valid flag until the word is taken
	bstk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage: entry memory, entry count, capacity, search key and index,
	// and the result register that parts the two channels
	bstk_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.data        (data),
		.found_index (found_index),
		.occupancy   (occupancy),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

endmodule
